FILE: hdl/ebc_pkg.sv
// shared types, constants and register codes of the encoder move brake controller
`timescale 1ns / 1ps
`default_nettype none

package ebc_pkg;

    localparam int DUTY_BITS  = 10;
    localparam int COUNT_BITS = 32;
    localparam int MARGIN_BITS = 16;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [DUTY_BITS-1:0]   BRAKE_DUTY_RST   = DUTY_BITS'((1 << DUTY_BITS) / 2 - 1);
    localparam logic [MARGIN_BITS-1:0] BRAKE_MARGIN_RST = MARGIN_BITS'(20);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DRIVE = 2'd1,
        PH_BRAKE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        BD_STOP = 2'd0,
        BD_FWD  = 2'd1,
        BD_REV  = 2'd2
    } t_dir;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_POLARITY_SWAP = 2'd0,
        CFG_BRAKE_DUTY    = 2'd1,
        CFG_BRAKE_MARGIN  = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic                   polarity_swap;
        logic [DUTY_BITS-1:0]   brake_duty;
        logic [MARGIN_BITS-1:0] brake_margin;
    } t_cfg;

    typedef struct packed {
        t_phase                       phase;
        t_dir                         dir;
        logic                         move_reverse;
        logic signed [COUNT_BITS-1:0] target_count;
        logic signed [COUNT_BITS-1:0] brake_target;
        logic [DUTY_BITS-1:0]         fwd_level;
        logic [DUTY_BITS-1:0]         rev_level;
    } t_ctrl_state;

    typedef struct packed {
        logic                 move_done;
        logic                 dead_time_wait;
        t_phase               move_phase;
        logic [DUTY_BITS-1:0] reverse_duty;
        logic [DUTY_BITS-1:0] forward_duty;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/ebc_step_logic.sv
// next-state and result logic for one controller request
`timescale 1ns / 1ps
`default_nettype none

module ebc_step_logic
    import ebc_pkg::*;
(
    input  wire t_ctrl_state                  i_state,
    input  wire t_cfg                         i_cfg,
    input  wire                               i_cmd,
    input  wire logic signed [COUNT_BITS-1:0] i_count,
    input  wire logic signed [COUNT_BITS-1:0] i_ticks,
    input  wire logic [DUTY_BITS-1:0]         i_duty,
    output t_ctrl_state                       o_state,
    output t_result                           o_result
);

    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    // saturate a one-bit-grown sum back to the count range
    function automatic logic signed [COUNT_BITS-1:0] sat_count(input logic [COUNT_BITS:0] s);
        logic signed [COUNT_BITS-1:0] r;
        if (s[COUNT_BITS] != s[COUNT_BITS-1]) begin
            r = s[COUNT_BITS] ? CNT_MIN : CNT_MAX;
        end else begin
            r = s[COUNT_BITS-1:0];
        end
        return r;
    endfunction

    logic [COUNT_BITS:0]          count_ext;
    logic [COUNT_BITS:0]          ticks_ext;
    logic [COUNT_BITS:0]          margin_ext;
    logic signed [COUNT_BITS-1:0] start_target;
    logic signed [COUNT_BITS-1:0] brake_fwd_target;
    logic signed [COUNT_BITS-1:0] brake_rev_target;
    logic                         reached;
    logic                         finished;
    logic                         drive_en;
    t_dir                         drive_dir;
    logic [DUTY_BITS-1:0]         drive_duty;
    logic                         wait_flag;
    logic                         done_flag;
    t_ctrl_state                  st;

    assign count_ext  = {i_count[COUNT_BITS-1], i_count};
    assign ticks_ext  = {i_ticks[COUNT_BITS-1], i_ticks};
    assign margin_ext = (COUNT_BITS+1)'(i_cfg.brake_margin);

    assign start_target     = sat_count(count_ext + ticks_ext);
    // forward move brakes back down, reverse move brakes back up
    assign brake_fwd_target = sat_count(count_ext - margin_ext);
    assign brake_rev_target = sat_count(count_ext + margin_ext);

    assign reached  = i_state.move_reverse ? (i_count <= i_state.target_count)
                                           : (i_count >= i_state.target_count);
    assign finished = i_state.move_reverse ? (i_count >= i_state.brake_target)
                                           : (i_count <= i_state.brake_target);

    always_comb begin
        st         = i_state;
        drive_en   = 1'b0;
        drive_dir  = BD_STOP;
        drive_duty = '0;
        done_flag  = 1'b0;

        priority if (i_cmd) begin
            st.target_count = start_target;
            st.move_reverse = i_ticks[COUNT_BITS-1];
            st.phase        = PH_DRIVE;
            drive_en        = 1'b1;
            drive_dir       = i_ticks[COUNT_BITS-1] ? BD_REV : BD_FWD;
            drive_duty      = i_duty;
        end else if (i_state.phase == PH_DRIVE) begin
            if (reached) begin
                st.brake_target = i_state.move_reverse ? brake_rev_target : brake_fwd_target;
                st.phase        = PH_BRAKE;
                drive_en        = 1'b1;
                drive_dir       = i_state.move_reverse ? BD_FWD : BD_REV;
                drive_duty      = i_cfg.brake_duty;
            end
        end else if (i_state.phase == PH_BRAKE) begin
            if (finished) begin
                st.phase   = PH_IDLE;
                drive_en   = 1'b1;
                drive_dir  = BD_STOP;
                done_flag  = 1'b1;
            end
        end else begin
            // sample while idle, everything holds
        end

        // bridge leg update
        wait_flag = 1'b0;
        if (drive_en) begin
            unique case (drive_dir)
                BD_FWD: begin
                    if (i_state.dir != BD_FWD) begin
                        st.rev_level = '0;
                        wait_flag    = 1'b1;
                    end
                    st.fwd_level = drive_duty;
                    st.dir       = BD_FWD;
                end
                BD_REV: begin
                    if (i_state.dir != BD_REV) begin
                        st.fwd_level = '0;
                        wait_flag    = 1'b1;
                    end
                    st.rev_level = drive_duty;
                    st.dir       = BD_REV;
                end
                default: begin
                    st.fwd_level = '0;
                    st.rev_level = '0;
                    st.dir       = BD_STOP;
                    wait_flag    = 1'b1;
                end
            endcase
        end

        o_state = st;
        o_result.forward_duty   = i_cfg.polarity_swap ? st.rev_level : st.fwd_level;
        o_result.reverse_duty   = i_cfg.polarity_swap ? st.fwd_level : st.rev_level;
        o_result.move_phase     = st.phase;
        o_result.dead_time_wait = wait_flag;
        o_result.move_done      = done_flag;
    end

endmodule

`default_nettype wire

FILE: hdl/encoder_move_brake_controller_unit.sv
// top level of the encoder move brake controller with stream ports and register port
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake                    | payload
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata: count, ticks, duty; tuser: cmd
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: duties, phase, wait, done
// cfg       | in        | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// one request per clock sustained while m_axis_tready stays high: an input register
// feeds the step logic, whose result and new state land in the output register
// on the same edge. synchronous active-low reset clears the controller state,
// the registers and both valid flags. a stalled result holds the output
// register while one more request waits in the input register.

module encoder_move_brake_controller_unit
    import ebc_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // stream in
    input  wire                      s_axis_tvalid,
    output logic                     s_axis_tready,
    // [31:0] encoder_count, [63:32] move_ticks, [73:64] move_duty, [79:74] zero
    input  wire [79:0]               s_axis_tdata,
    // [0] cmd
    input  wire [0:0]                s_axis_tuser,
    // stream out
    output logic                     m_axis_tvalid,
    input  wire                      m_axis_tready,
    // [9:0] forward_duty, [19:10] reverse_duty, [21:20] move_phase,
    // [22] dead_time_wait, [23] move_done
    output logic [23:0]              m_axis_tdata,
    // register writes
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire [MARGIN_BITS-1:0]    i_cfg_data
);

    // input register
    logic                         r_in_valid;
    logic                         r_in_cmd;
    logic signed [COUNT_BITS-1:0] r_in_count;
    logic signed [COUNT_BITS-1:0] r_in_ticks;
    logic [DUTY_BITS-1:0]         r_in_duty;

    // controller state, registers and output register
    t_ctrl_state r_state;
    t_ctrl_state n_state;
    t_cfg        r_cfg;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;

    logic advance;
    logic in_take;

    // a request moves on when the output slot is free or being emptied
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd   <= s_axis_tuser[0];
            r_in_count <= s_axis_tdata[31:0];
            r_in_ticks <= s_axis_tdata[63:32];
            r_in_duty  <= s_axis_tdata[73:64];
        end
    end

    // register writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.polarity_swap <= 1'b0;
            r_cfg.brake_duty    <= BRAKE_DUTY_RST;
            r_cfg.brake_margin  <= BRAKE_MARGIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POLARITY_SWAP: r_cfg.polarity_swap <= i_cfg_data[0];
                CFG_BRAKE_DUTY:    r_cfg.brake_duty    <= i_cfg_data[DUTY_BITS-1:0];
                CFG_BRAKE_MARGIN:  r_cfg.brake_margin  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ebc_step_logic u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_cmd    (r_in_cmd),
        .i_count  (r_in_count),
        .i_ticks  (r_in_ticks),
        .i_duty   (r_in_duty),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // state commits when its request reaches the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_IDLE;
            r_state.dir          <= BD_STOP;
            r_state.move_reverse <= 1'b0;
            r_state.target_count <= '0;
            r_state.brake_target <= '0;
            r_state.fwd_level    <= '0;
            r_state.rev_level    <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // a finished brake always ends idle and with a dead-time wait
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.move_done |->
            r_out.move_phase == PH_IDLE && r_out.dead_time_wait)
        else $error("move_done without idle stop");

    // idle controller holds both legs off
    a_idle_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_IDLE |-> r_state.fwd_level == '0 && r_state.rev_level == '0)
        else $error("bridge leg active while idle");

    // driving forward never leaves the reverse leg on
    a_fwd_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.dir == BD_FWD |-> r_state.rev_level == '0)
        else $error("reverse leg on while forward");

    // state changes only when a request is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("state moved without a request");

endmodule

`default_nettype wire

FILE: bench/tb_encoder_move_brake_controller_unit.sv
// testbench for the encoder move brake controller: predicts each bridge step and checks it
`timescale 1ns / 1ps

module tb_encoder_move_brake_controller_unit;
    import ebc_pkg::*;

    // run limit in clock cycles, several times the slowest legal run
    localparam int CYCLE_LIMIT = 500_000;
    // register index past the end of the map, the block must ignore it
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam longint CNT_MAX = 64'sd2147483647;
    localparam longint CNT_MIN = -64'sd2147483648;

    // one stream request as the sender sees it
    typedef struct {
        bit                 cmd;
        logic signed [31:0] count;
        logic signed [31:0] ticks;
        logic [9:0]         duty;
    } t_motor_req;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [79:0]               s_axis_tdata = '0;
    logic [0:0]                s_axis_tuser = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [23:0]               m_axis_tdata;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [MARGIN_BITS-1:0]    i_cfg_data = '0;

    encoder_move_brake_controller_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // register mirror, follows every accepted register write
    logic                   cfg_swap = 1'b0;
    logic [DUTY_BITS-1:0]   cfg_brake_duty = BRAKE_DUTY_RST;
    logic [MARGIN_BITS-1:0] cfg_margin = BRAKE_MARGIN_RST;

    // controller state as the bench predicts it
    t_phase         ctl_phase = PH_IDLE;
    t_dir           ctl_dir = BD_STOP;
    bit             ctl_reverse = 1'b0;
    longint         ctl_target = 0;
    longint         ctl_brake_at = 0;
    logic [9:0]     ctl_fwd_lvl = '0;
    logic [9:0]     ctl_rev_lvl = '0;

    t_motor_req     pending_req_q[$];   // requests not yet offered to the block
    t_result        bridge_out_q[$];    // predicted bridge steps, oldest first
    t_motor_req     cur_req;            // request currently on the input bus
    bit             in_taken = 1'b0;    // input handshake seen at the last rising edge
    int             src_gap = 0;
    int             sink_gap = 0;
    int             sink_hold = 0;      // long receiver hold-off, counted down by the sink
    bit             src_calm = 1'b0;
    bit             sink_calm = 1'b0;
    int             n_err = 0;
    int             n_cycles = 0;
    int             n_queued = 0;
    longint         gen_pos = 0;        // encoder position the stimulus walks

    // count range is the signed 32-bit range, sums saturate instead of wrapping
    function automatic longint sat32(longint v);
        if (v > CNT_MAX) return CNT_MAX;
        if (v < CNT_MIN) return CNT_MIN;
        return v;
    endfunction

    // switch the bridge, returns 1 when the dead-time pause is needed
    function automatic bit set_bridge(logic [9:0] duty, t_dir d);
        bit wt;
        wt = 1'b0;
        if (d == BD_FWD) begin
            if (ctl_dir != BD_FWD) begin
                ctl_rev_lvl = '0;
                wt = 1'b1;
            end
            ctl_fwd_lvl = duty;
            ctl_dir = BD_FWD;
        end else if (d == BD_REV) begin
            if (ctl_dir != BD_REV) begin
                ctl_fwd_lvl = '0;
                wt = 1'b1;
            end
            ctl_rev_lvl = duty;
            ctl_dir = BD_REV;
        end else begin
            ctl_fwd_lvl = '0;
            ctl_rev_lvl = '0;
            ctl_dir = BD_STOP;
            wt = 1'b1;
        end
        return wt;
    endfunction

    // one controller step: start, target check while driving, or end-of-brake check
    function automatic t_result bridge_predict(t_motor_req r);
        t_result res;
        bit      wt;
        bit      dn;
        longint  c;
        longint  m;
        wt = 1'b0;
        dn = 1'b0;
        c = r.count;
        m = cfg_margin;
        if (r.cmd) begin
            ctl_target = sat32(c + r.ticks);
            ctl_reverse = (r.ticks < 0);
            wt = set_bridge(r.duty, ctl_reverse ? BD_REV : BD_FWD);
            ctl_phase = PH_DRIVE;
        end else if (ctl_phase == PH_DRIVE) begin
            if (ctl_reverse ? (c <= ctl_target) : (c >= ctl_target)) begin
                wt = set_bridge(cfg_brake_duty, ctl_reverse ? BD_FWD : BD_REV);
                ctl_brake_at = ctl_reverse ? sat32(c + m) : sat32(c - m);
                ctl_phase = PH_BRAKE;
            end
        end else if (ctl_phase == PH_BRAKE) begin
            if (ctl_reverse ? (c >= ctl_brake_at) : (c <= ctl_brake_at)) begin
                wt = set_bridge('0, BD_STOP);
                ctl_phase = PH_IDLE;
                dn = 1'b1;
            end
        end
        res.forward_duty   = cfg_swap ? ctl_rev_lvl : ctl_fwd_lvl;
        res.reverse_duty   = cfg_swap ? ctl_fwd_lvl : ctl_rev_lvl;
        res.move_phase     = ctl_phase;
        res.dead_time_wait = wt;
        res.move_done      = dn;
        return res;
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic void add_req(bit cmd, longint cnt, longint ticks, int unsigned duty);
        t_motor_req r;
        r.cmd   = cmd;
        r.count = cnt[31:0];
        r.ticks = ticks[31:0];
        r.duty  = duty[9:0];
        pending_req_q.push_back(r);
        n_queued++;
    endfunction

    // encoder sample, the start-only fields carry random junk
    function automatic void add_sample(longint cnt);
        add_req(1'b0, cnt, longint'($signed($urandom)), $urandom_range(0, 1023));
    endfunction

    // one move: start, samples walking to the target, then back through the brake margin.
    // now and then a noise request, a jump to the count extremes, or a move cut short
    function automatic void gen_move();
        int     r;
        int     dir;
        int     k;
        longint ticks;
        longint tgt;
        longint brk;
        longint mag;
        longint stepsz;
        longint mv;
        longint m;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            add_req(1'($urandom_range(0, 1)), longint'($signed($urandom)),
                    longint'($signed($urandom)), $urandom_range(0, 1023));
            return;
        end
        if (r < 14) begin
            k = $urandom_range(0, 2);
            if (k == 0) gen_pos = CNT_MAX - longint'($urandom_range(0, 60));
            else if (k == 1) gen_pos = CNT_MIN + longint'($urandom_range(0, 60));
            else gen_pos = longint'($signed($urandom));
        end
        r = $urandom_range(0, 99);
        if (r < 5) ticks = 0;
        else if (r < 15) ticks = longint'($signed($urandom));
        else begin
            ticks = longint'($urandom_range(1, 300));
            if ($urandom_range(0, 1)) ticks = -ticks;
        end
        add_req(1'b1, gen_pos, ticks, $urandom_range(0, 1023));
        tgt = sat32(gen_pos + ticks);
        dir = (ticks < 0) ? -1 : 1;
        mag = (tgt > gen_pos) ? tgt - gen_pos : gen_pos - tgt;
        stepsz = mag / longint'($urandom_range(1, 10)) + 1;
        k = 0;
        while (dir > 0 ? gen_pos < tgt : gen_pos > tgt) begin
            mv = stepsz;
            if ($urandom_range(0, 3) == 0) mv = stepsz / 2;
            if ($urandom_range(0, 9) == 0) mv = -mv;
            gen_pos = (k >= 40) ? tgt : sat32(gen_pos + dir * mv);
            add_sample(gen_pos);
            k++;
            // a fresh start replaces the move in flight
            if ($urandom_range(0, 29) == 0) return;
        end
        m = cfg_margin;
        brk = sat32(gen_pos - dir * m);
        mag = (brk > gen_pos) ? brk - gen_pos : gen_pos - brk;
        stepsz = mag / longint'($urandom_range(1, 6)) + 1;
        k = 0;
        do begin
            mv = stepsz;
            if ($urandom_range(0, 3) == 0) mv = stepsz / 3;
            if ($urandom_range(0, 9) == 0) mv = -mv;
            gen_pos = (k >= 40) ? brk : sat32(gen_pos - dir * mv);
            add_sample(gen_pos);
            k++;
        end while (dir > 0 ? gen_pos > brk : gen_pos < brk);
        // a few samples while idle
        repeat ($urandom_range(0, 2)) add_sample(gen_pos);
    endfunction

    function automatic void gen_random(int n);
        int goal;
        goal = n_queued + n;
        while (n_queued < goal) gen_move();
    endfunction

    // input side: posedge sees the request, the predictor advances at that moment
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            bridge_out_q.push_back(bridge_predict(cur_req));
            in_taken = 1'b1;
        end
    end

    // input driver, changes the bus at the falling edge
    always @(negedge i_clk) begin : drv
        logic nv;
        nv = s_axis_tvalid;
        if (in_taken) begin
            in_taken = 1'b0;
            nv = 1'b0;
        end
        if ($urandom_range(0, 199) == 0) src_calm = !src_calm;
        if (!nv && i_rst_n) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (pending_req_q.size() > 0) begin
                cur_req = pending_req_q.pop_front();
                nv = 1'b1;
                // pad, duty, ticks, count from the top down
                s_axis_tdata <= {6'b0, cur_req.duty, cur_req.ticks, cur_req.count};
                s_axis_tuser <= cur_req.cmd;
                src_gap = src_calm ? 0 : pick_gap();
            end
        end
        s_axis_tvalid <= nv;
    end

    // output ready, random stalls plus the long hold-off
    always @(negedge i_clk) begin : sink
        logic rdy;
        if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
        if (sink_hold > 0) begin
            sink_hold--;
            rdy = 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
            if (!sink_calm && $urandom_range(0, 2) == 0) sink_gap = pick_gap();
        end
        m_axis_tready <= rdy;
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_err++;
        end
    endfunction

    // output side: each result against the oldest prediction
    always @(posedge i_clk) begin : mon
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata);
            if (bridge_out_q.size() == 0) begin
                $error("result with no request pending: %h", m_axis_tdata);
                n_err++;
            end else begin
                want = bridge_out_q.pop_front();
                check_field("forward_duty", want.forward_duty, got.forward_duty);
                check_field("reverse_duty", want.reverse_duty, got.reverse_duty);
                check_field("move_phase", want.move_phase, got.move_phase);
                check_field("dead_time_wait", want.dead_time_wait, got.dead_time_wait);
                check_field("move_done", want.move_done, got.move_done);
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // register write through the config channel, mirror follows on the handshake
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [MARGIN_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_POLARITY_SWAP: cfg_swap = val[0];
            CFG_BRAKE_DUTY:    cfg_brake_duty = val[DUTY_BITS-1:0];
            CFG_BRAKE_MARGIN:  cfg_margin = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until every request went in and every result came out, then let the pipe settle
    task automatic drain();
        while (pending_req_q.size() > 0 || s_axis_tvalid || bridge_out_q.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with reset register values (margin 20, brake duty 511)
        add_sample(0);                            // sample while idle
        add_req(1'b1, 100, 0, 1023);              // zero offset counts as forward
        add_sample(100);                          // target met at once, brake
        add_sample(90);
        add_sample(80);                           // brake margin covered, stop
        add_req(1'b1, CNT_MAX, CNT_MAX, 0);       // target saturates high
        add_sample(CNT_MAX);
        add_req(1'b1, CNT_MIN, CNT_MIN, 1023);    // start while braking, reverse
        add_req(1'b1, -5, -1, 10'h2AA);           // same direction again, no dead time
        add_sample(-6);
        add_sample(13);
        add_sample(14);
        add_req(1'b1, CNT_MIN, -1, 10'h155);      // target saturates low
        add_sample(CNT_MIN);
        add_sample(CNT_MIN + 20);
        add_req(1'b1, 64'sh55555555, 64'shAAAAAAAA - 64'sh100000000, 10'h155);
        add_req(1'b1, 0, 1, 10'h2AA);             // start while driving, forward again
        add_sample(1);
        add_sample(-19);
        add_sample(64'shAAAAAAAA - 64'sh100000000);
        drain();

        // swapped legs, full brake duty, no margin
        write_reg(CFG_POLARITY_SWAP, 16'd1);
        write_reg(CFG_BRAKE_DUTY, 16'd1023);
        write_reg(CFG_BRAKE_MARGIN, 16'd0);
        gen_random(260);
        drain();

        // zero brake duty, widest margin, and a write to an unused index
        write_reg(CFG_POLARITY_SWAP, 16'd0);
        write_reg(CFG_BRAKE_DUTY, 16'd0);
        write_reg(CFG_BRAKE_MARGIN, 16'hFFFF);
        write_reg(CFG_SPARE, 16'hFFFF);
        gen_random(260);
        drain();

        // random settings, sender pauses halfway until every result is back
        write_reg(CFG_POLARITY_SWAP, 16'($urandom_range(0, 1)));
        write_reg(CFG_BRAKE_DUTY, 16'($urandom_range(0, 1023)));
        write_reg(CFG_BRAKE_MARGIN, 16'($urandom_range(1, 300)));
        gen_random(130);
        drain();
        gen_random(130);
        drain();

        // receiver holds off long while requests keep coming, so the block backs up
        write_reg(CFG_POLARITY_SWAP, 16'd1);
        write_reg(CFG_BRAKE_DUTY, 16'd511);
        write_reg(CFG_BRAKE_MARGIN, 16'($urandom_range(0, 40)));
        gen_random(260);
        sink_hold = 400;
        drain();

        repeat (10) @(posedge i_clk);
        if (n_err == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
